// ----- design/dxt_motion_block_video_decoder_unit_defines.svh -----
// ---------------------------------------------------------------------------
// DXT motion block decoder assertion macros
// Shared concurrent assertion forms.
// ---------------------------------------------------------------------------
`ifndef DXT_MOTION_BLOCK_VIDEO_DECODER_UNIT_DEFINES_SVH
`define DXT_MOTION_BLOCK_VIDEO_DECODER_UNIT_DEFINES_SVH

// condition implies consequence on the same edge
`define DXT_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence on the next edge
`define DXT_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dxtmv_pkg.sv -----
// ---------------------------------------------------------------------------
// DXT motion block decoder package
// Shared types, codes and palette helper.
// ---------------------------------------------------------------------------
package dxtmv_pkg;

  typedef enum logic [4:0] {
    PH_WAIT   = 5'b00001,
    PH_DUMMY  = 5'b00010,
    PH_BLOCK  = 5'b00100,
    PH_COLOR1 = 5'b01000,
    PH_INDEX  = 5'b10000
  } phase_t;

  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_CUR  = 2'd1;
  localparam logic [1:0] KIND_PREV = 2'd2;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  localparam logic [15:0] KEEP_BIT = 16'h0040;
  localparam int unsigned MV_BIAS  = 15;
  localparam logic [4:0]  FLAG_CNT = 5'd16;

  // pixel run request from parser to emitter
  typedef struct packed {
    logic        motion;
    logic [1:0]  kind;
    logic        small_unit;
    logic [15:0] base;
    logic [16:0] offs;
    logic [15:0] idx_word;
  } run_t;

  // truncated (2a+b)/3 on one 5-bit channel, reciprocal multiply
  function automatic logic [4:0] third5(input logic [4:0] a, input logic [4:0] b);
    logic [6:0]  s;
    logic [13:0] p;
    begin
      s = {1'b0, a, 1'b0} + {2'b00, b};
      p = 14'(s) * 14'd43;
      third5 = p[11:7];
    end
  endfunction

  function automatic logic [15:0] third(input logic [15:0] a, input logic [15:0] b);
    begin
      third = {1'b0, third5(a[14:10], b[14:10]), third5(a[9:5], b[9:5]),
               third5(a[4:0], b[4:0])};
    end
  endfunction

endpackage

// ----- design/dxt_motion_block_video_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// DXT motion block video decoder
// Stream word parser feeding a one-pixel-per-cycle, stallable command emitter.
// ---------------------------------------------------------------------------
// The first pixel of a run is registered at the emitter output after the
//   run is loaded into run_r by the word transfer. An index word makes 8
//   pixels, a motion word 16 or 64: one pixel per cycle from the emitter's
//   address adder unless out_ready stalls; in_ready is low while busy.
// Reset (rst_n low, synchronous): waits for a frame header, palette zero,
//   width 30 and height 20 blocks.
module dxt_motion_block_video_decoder_unit #(
  parameter int LINE_STRIDE = 240
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [5:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_stream_word,
  input  logic              in_frame_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_pixel_kind,
  output logic [15:0]       out_dest_index,
  output logic signed [16:0] out_src_index,
  output logic [15:0]       out_pixel_color,
  output logic              out_run_last
);

`include "dxt_motion_block_video_decoder_unit_defines.svh"

  logic [4:0] wb_r;
  logic [5:0] hb_r;
  logic       take, start, busy;
  dxtmv_pkg::run_t run;
  dxtmv_pkg::phase_t phase;
  logic [15:0] pal0, pal1, pal2, pal3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= 5'd30;
      hb_r <= 6'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        dxtmv_pkg::CFG_WIDTH:  wb_r <= cfg_data[4:0];
        dxtmv_pkg::CFG_HEIGHT: hb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !busy;
  assign take = in_valid && in_ready;

  dxtmv_parse #(.LINE_STRIDE(LINE_STRIDE)) u_parse (
    .clk(clk), .rst_n(rst_n), .take(take), .word(in_stream_word),
    .hdr(in_frame_start), .wb(wb_r), .hb(hb_r), .start(start), .run(run),
    .pal0(pal0), .pal1(pal1), .pal2(pal2), .pal3(pal3), .phase(phase)
  );

  dxtmv_emit #(.LINE_STRIDE(LINE_STRIDE)) u_emit (
    .clk(clk), .rst_n(rst_n), .start(start), .run(run),
    .pal0(pal0), .pal1(pal1), .pal2(pal2), .pal3(pal3), .busy(busy),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_kind(out_pixel_kind), .out_dest_index(out_dest_index),
    .out_src_index(out_src_index), .out_pixel_color(out_pixel_color),
    .out_run_last(out_run_last)
  );

  `DXT_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy, "run start did not set busy")
  `DXT_ASSERT_IMP(a_lit_src, clk, rst_n, out_valid && out_pixel_kind == dxtmv_pkg::KIND_LIT,
    out_src_index == 17'sd0, "literal pixel with nonzero source")
  `DXT_ASSERT_IMP(a_start_take, clk, rst_n, start, take, "run start without transfer")
  `DXT_ASSERT_IMP(a_wait_idle, clk, rst_n, phase == dxtmv_pkg::PH_WAIT && !take,
    !start, "run start while waiting for header")

endmodule

// ----- design/dxtmv_emit.sv -----
// ---------------------------------------------------------------------------
// DXT motion block decoder pixel emitter
// Steps one pixel per cycle unless out_ready stalls, using address adders.
// ---------------------------------------------------------------------------
module dxtmv_emit #(
  parameter int LINE_STRIDE = 240
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dxtmv_pkg::run_t   run,
  input  logic [15:0]       pal0,
  input  logic [15:0]       pal1,
  input  logic [15:0]       pal2,
  input  logic [15:0]       pal3,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_pixel_kind,
  output logic [15:0]       out_dest_index,
  output logic signed [16:0] out_src_index,
  output logic [15:0]       out_pixel_color,
  output logic              out_run_last
);

  logic            busy_r, busy_nxt;
  dxtmv_pkg::run_t run_r;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [15:0]     dest_r, dest_nxt;
  logic [15:0]     rowb_r, rowb_nxt;
  logic            ov_r, ov_nxt;
  logic [1:0]      kind_r;
  logic [15:0]     dq_r, col_r;
  logic [16:0]     sq_r;
  logic            last_r;
  logic [5:0]      last_cnt;
  logic [2:0]      xmask;
  logic [15:0]     ncol;
  logic [1:0]      sel;
  logic            step, at_row_end;

  assign busy = busy_r;
  assign last_cnt = run_r.motion ? (run_r.small_unit ? 6'd15 : 6'd63) : 6'd7;
  assign xmask = run_r.small_unit ? 3'd3 : 3'd7;
  assign at_row_end = (cnt_r[2:0] & xmask) == xmask;
  assign step = busy_r && (!ov_r || out_ready);
  assign sel = run_r.idx_word[{cnt_r[2:0], 1'b0} +: 2];

  always_comb begin
    case (sel)
      2'd0:    ncol = pal0;
      2'd1:    ncol = pal1;
      2'd2:    ncol = pal2;
      default: ncol = pal3;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dest_nxt = dest_r;
    rowb_nxt = rowb_r;
    ov_nxt   = ov_r && !out_ready;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dest_nxt = run.base;
      rowb_nxt = run.base;
    end else if (step) begin
      ov_nxt  = 1'b1;
      cnt_nxt = cnt_r + 6'd1;
      if (at_row_end) begin
        dest_nxt = rowb_r + 16'(LINE_STRIDE);
        rowb_nxt = rowb_r + 16'(LINE_STRIDE);
      end else begin
        dest_nxt = dest_r + 16'd1;
      end
      if (cnt_r == last_cnt) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    cnt_r  <= cnt_nxt;
    dest_r <= dest_nxt;
    rowb_r <= rowb_nxt;
    if (start) run_r <= run;
    if (step) begin
      kind_r <= run_r.kind;
      dq_r   <= dest_r;
      sq_r   <= run_r.motion ? ({1'b0, dest_r} + run_r.offs) : 17'd0;
      col_r  <= run_r.motion ? 16'd0 : ncol;
      last_r <= cnt_r == last_cnt;
    end
  end

  assign out_valid       = ov_r;
  assign out_pixel_kind  = kind_r;
  assign out_dest_index  = dq_r;
  assign out_src_index   = sq_r;
  assign out_pixel_color = col_r;
  assign out_run_last    = last_r;

endmodule

// ----- design/dxtmv_parse.sv -----
// ---------------------------------------------------------------------------
// DXT motion block decoder stream parser
// Walks the frame block grid and holds the palette.
// ---------------------------------------------------------------------------
module dxtmv_parse #(
  parameter int LINE_STRIDE = 240
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [15:0]     word,
  input  logic            hdr,
  input  logic [4:0]      wb,
  input  logic [5:0]      hb,
  output logic            start,
  output dxtmv_pkg::run_t run,
  output logic [15:0]     pal0,
  output logic [15:0]     pal1,
  output logic [15:0]     pal2,
  output logic [15:0]     pal3,
  output dxtmv_pkg::phase_t phase
);

  dxtmv_pkg::phase_t ph_r, ph_nxt;
  logic [15:0] spl_r, spl_nxt;
  logic [4:0]  fl_r, fl_nxt;
  logic [4:0]  col_r, col_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [2:0]  iw_r, iw_nxt;
  logic [15:0] p0_r, p1_r, p2_r, p3_r;
  logic        sp, fin, mv;
  logic [15:0] xoff, base;
  logic [2:0]  iw_inc;
  logic [16:0] moff;
  logic signed [16:0] dxs, dys;

  assign sp = spl_r[0];
  assign xoff  = 16'({col_r, 3'b000}) + (sp ? 16'({ch_r[0], 2'b00}) : 16'd0);
  assign iw_inc = iw_r + 3'd1;
  assign mv = word[15];

  // dest base = (unit_y + word row) * stride + unit_x; one multiplier
  logic [15:0] yrow;
  always_comb begin
    yrow = {row_r, 3'b000};
    if (sp) yrow = yrow + 16'({ch_r[1], 2'b00});
    if (ph_r == dxtmv_pkg::PH_INDEX) yrow = yrow + (sp ? 16'({iw_r, 1'b0}) : 16'(iw_r));
    base = 16'(yrow * 16'(LINE_STRIDE)) + xoff;
  end

  assign dxs = 17'(signed'({1'b0, word[4:0]})) - 17'(dxtmv_pkg::MV_BIAS);
  assign dys = 17'(signed'({1'b0, word[9:5]})) - 17'(dxtmv_pkg::MV_BIAS);
  assign moff = 17'(dys * 17'(LINE_STRIDE)) + dxs;

  always_comb begin
    run.motion     = ph_r == dxtmv_pkg::PH_BLOCK;
    run.kind       = (ph_r == dxtmv_pkg::PH_BLOCK) ?
                     (word[14] ? dxtmv_pkg::KIND_PREV : dxtmv_pkg::KIND_CUR) :
                     dxtmv_pkg::KIND_LIT;
    run.small_unit = sp;
    run.base       = base;
    run.offs       = moff;
    run.idx_word   = word;
  end

  always_comb begin
    ph_nxt = ph_r; spl_nxt = spl_r; fl_nxt = fl_r; col_nxt = col_r;
    row_nxt = row_r; ch_nxt = ch_r; iw_nxt = iw_r;
    start = 1'b0; fin = 1'b0;
    if (take) begin
      if (hdr) begin
        ph_nxt = (word & dxtmv_pkg::KEEP_BIT) != 16'd0 ? dxtmv_pkg::PH_WAIT :
                 dxtmv_pkg::PH_DUMMY;
        spl_nxt = '0; fl_nxt = '0; col_nxt = '0; row_nxt = '0; ch_nxt = '0; iw_nxt = '0;
      end else begin
        case (ph_r)
          dxtmv_pkg::PH_DUMMY: begin
            col_nxt = '0; row_nxt = '0; ch_nxt = '0; fl_nxt = '0;
            ph_nxt = (wb == 5'd0 || hb == 6'd0) ? dxtmv_pkg::PH_WAIT : dxtmv_pkg::PH_BLOCK;
          end
          dxtmv_pkg::PH_BLOCK: begin
            if (fl_r == 5'd0) begin
              spl_nxt = word; fl_nxt = dxtmv_pkg::FLAG_CNT;
            end else if (mv) begin
              start = 1'b1; fin = 1'b1;
            end else begin
              ph_nxt = dxtmv_pkg::PH_COLOR1;
            end
          end
          dxtmv_pkg::PH_COLOR1: begin
            iw_nxt = '0; ph_nxt = dxtmv_pkg::PH_INDEX;
          end
          dxtmv_pkg::PH_INDEX: begin
            start = 1'b1;
            iw_nxt = iw_inc;
            if (iw_inc == (sp ? 3'd2 : 3'd0)) begin
              iw_nxt = '0; ph_nxt = dxtmv_pkg::PH_BLOCK; fin = 1'b1;
            end
          end
          default: ;
        endcase
        if (fin) begin
          if (sp && ch_r != 2'd3) begin
            ch_nxt = ch_r + 2'd1;
          end else begin
            ch_nxt = '0;
            spl_nxt = spl_r >> 1;
            fl_nxt = (fl_r != 5'd0) ? fl_r - 5'd1 : 5'd0;
            if ({1'b0, col_r} + 6'd1 >= {1'b0, wb}) begin
              col_nxt = '0; fl_nxt = '0; spl_nxt = '0;
              if ({1'b0, row_r} + 6'd1 >= hb) begin
                row_nxt = '0; ph_nxt = dxtmv_pkg::PH_WAIT;
              end else begin
                row_nxt = row_r + 5'd1;
              end
            end else begin
              col_nxt = col_r + 5'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= dxtmv_pkg::PH_WAIT;
      spl_r <= '0; fl_r <= '0; col_r <= '0; row_r <= '0; ch_r <= '0; iw_r <= '0;
      p0_r <= '0; p1_r <= '0; p2_r <= '0; p3_r <= '0;
    end else begin
      ph_r <= ph_nxt; spl_r <= spl_nxt; fl_r <= fl_nxt; col_r <= col_nxt;
      row_r <= row_nxt; ch_r <= ch_nxt; iw_r <= iw_nxt;
      if (take && !hdr && ph_r == dxtmv_pkg::PH_BLOCK && fl_r != 5'd0 && !mv)
        p0_r <= word;
      if (take && !hdr && ph_r == dxtmv_pkg::PH_COLOR1) begin
        p1_r <= word;
        p2_r <= dxtmv_pkg::third(p0_r, word);
        p3_r <= dxtmv_pkg::third(word, p0_r);
      end
    end
  end

  assign pal0 = p0_r; assign pal1 = p1_r; assign pal2 = p2_r; assign pal3 = p3_r;
  assign phase = ph_r;

endmodule

// ----- tb/tb_dxt_motion_block_video_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// DXT motion block video decoder testbench
// Feeds frame streams through valid/ready with random gaps, predicts every
// pixel command from a local decoder model, and checks them in order.
// ---------------------------------------------------------------------------
module tb_dxt_motion_block_video_decoder_unit;

  localparam int STRIDE    = 240;
  localparam int CYCLE_CAP = 1000000;
  localparam int SETTLE    = 80;

  typedef struct {
    logic [15:0] w;
    logic        fs;
  } word_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] dest;
    logic [16:0] src;
    logic [15:0] color;
    logic        last;
  } pix_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [5:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_stream_word;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_pixel_kind;
  logic [15:0] out_dest_index;
  logic signed [16:0] out_src_index;
  logic [15:0] out_pixel_color;
  logic        out_run_last;

  dxt_motion_block_video_decoder_unit dut (.*);

  word_t pend_words[$];
  pix_t  pix_q[$];
  int    errors = 0;
  int    cycles = 0;
  bit    fast = 0;
  bit    hold_req = 0;
  bit    in_done = 0;
  bit    out_done = 0;
  int    in_gap = 0;
  int    out_stall = 0;
  int    hold_left = 0;
  int    gen_count;

  // decoder model state
  logic [4:0]  m_width;
  logic [5:0]  m_height;
  dxtmv_pkg::phase_t m_phase;
  logic [15:0] m_flags;
  int          m_flags_left, m_col, m_row, m_child, m_iwc;
  logic [15:0] m_pal[4];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report(input string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] r;
    r = 16'h0;
    for (int c = 0; c < 3; c++)
      r[c*5 +: 5] = 5'((2 * int'(a[c*5 +: 5]) + int'(b[c*5 +: 5])) / 3);
    return r;
  endfunction

  task automatic model_reset();
    m_width = 5'd30;
    m_height = 6'd20;
    m_phase = dxtmv_pkg::PH_WAIT;
    m_flags = '0;
    m_flags_left = 0; m_col = 0; m_row = 0; m_child = 0; m_iwc = 0;
    for (int i = 0; i < 4; i++) m_pal[i] = '0;
  endtask

  task automatic next_unit();
    if (m_flags[0]) begin
      m_child = (m_child + 1) & 3;
      if (m_child != 0) return;
    end
    m_child = 0;
    m_flags = m_flags >> 1;
    m_flags_left = (m_flags_left > 0) ? m_flags_left - 1 : 0;
    if (m_col + 1 >= int'(m_width)) begin
      m_col = 0;
      m_flags_left = 0;
      m_flags = '0;
      if (m_row + 1 >= int'(m_height)) begin
        m_row = 0;
        m_phase = dxtmv_pkg::PH_WAIT;
      end else begin
        m_row = (m_row + 1) & 31;
      end
    end else begin
      m_col = (m_col + 1) & 31;
    end
  endtask

  task automatic push_pix(input logic [1:0] k, input int d, input int s,
                          input logic [15:0] c);
    pix_t p;
    p.kind = k;
    p.dest = d[15:0];
    p.src = s[16:0];
    p.color = c;
    p.last = 1'b0;
    pix_q.push_back(p);
  endtask

  task automatic decode_word(input logic [15:0] w, input logic fs);
    int n0, y0, x0, sz, dx, dy, d, ry, cx;
    bit sp;
    logic [1:0] k;
    n0 = pix_q.size();
    sp = m_flags[0];
    y0 = m_row * 8 + (sp ? (m_child >> 1) * 4 : 0);
    x0 = m_col * 8 + (sp ? (m_child & 1) * 4 : 0);
    if (fs) begin
      m_phase = (w & dxtmv_pkg::KEEP_BIT) ? dxtmv_pkg::PH_WAIT : dxtmv_pkg::PH_DUMMY;
      m_flags = '0;
      m_flags_left = 0; m_col = 0; m_row = 0; m_child = 0; m_iwc = 0;
      return;
    end
    case (m_phase)
      dxtmv_pkg::PH_DUMMY: begin
        m_col = 0; m_row = 0; m_child = 0; m_flags_left = 0;
        m_phase = (m_width == 0 || m_height == 0) ? dxtmv_pkg::PH_WAIT :
                  dxtmv_pkg::PH_BLOCK;
      end
      dxtmv_pkg::PH_BLOCK: begin
        if (m_flags_left == 0) begin
          m_flags = w;
          m_flags_left = dxtmv_pkg::FLAG_CNT;
        end else if (w[15]) begin
          k = w[14] ? dxtmv_pkg::KIND_PREV : dxtmv_pkg::KIND_CUR;
          dx = int'(w[4:0]) - int'(dxtmv_pkg::MV_BIAS);
          dy = int'(w[9:5]) - int'(dxtmv_pkg::MV_BIAS);
          sz = sp ? 4 : 8;
          for (int y = 0; y < sz; y++)
            for (int x = 0; x < sz; x++) begin
              d = (y0 + y) * STRIDE + x0 + x;
              push_pix(k, d, d + dy * STRIDE + dx, 16'h0);
            end
          next_unit();
        end else begin
          m_pal[0] = w;
          m_phase = dxtmv_pkg::PH_COLOR1;
        end
      end
      dxtmv_pkg::PH_COLOR1: begin
        m_pal[1] = w;
        m_pal[2] = blend(m_pal[0], m_pal[1]);
        m_pal[3] = blend(m_pal[1], m_pal[0]);
        m_iwc = 0;
        m_phase = dxtmv_pkg::PH_INDEX;
      end
      dxtmv_pkg::PH_INDEX: begin
        for (int i = 0; i < 8; i++) begin
          ry = sp ? m_iwc * 2 + (i >> 2) : m_iwc;
          cx = sp ? (i & 3) : i;
          push_pix(dxtmv_pkg::KIND_LIT, (y0 + ry) * STRIDE + x0 + cx, 0,
                   m_pal[w[2*i +: 2]]);
        end
        m_iwc = (m_iwc + 1) & 7;
        if (m_iwc == (sp ? 2 : 0)) begin
          m_iwc = 0;
          m_phase = dxtmv_pkg::PH_BLOCK;
          next_unit();
        end
      end
      default: ;
    endcase
    if (pix_q.size() > n0) pix_q[pix_q.size() - 1].last = 1'b1;
  endtask

  // input side
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      decode_word(in_stream_word, in_frame_start);
      in_done = 1;
    end
  end

  always @(negedge clk) begin : drive_in
    logic nv;
    word_t it;
    nv = in_valid;
    if (in_done) begin
      nv = 1'b0;
      in_done = 0;
      in_gap = fast ? 0 : $urandom_range(0, 11);
    end
    if (!nv && rst_n) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pend_words.size() > 0) begin
        it = pend_words.pop_front();
        in_stream_word <= it.w;
        in_frame_start <= it.fs;
        nv = 1'b1;
      end
    end
    in_valid <= nv;
  end

  // result side
  always @(posedge clk) begin : check_out
    pix_t e;
    if (rst_n && out_valid && out_ready) begin
      out_done = 1;
      if (pix_q.size() == 0) begin
        report($sformatf("unexpected pixel dest=%0d", out_dest_index));
      end else begin
        e = pix_q.pop_front();
        if (out_pixel_kind !== e.kind)
          report($sformatf("kind %0d exp %0d", out_pixel_kind, e.kind));
        if (out_dest_index !== e.dest)
          report($sformatf("dest %0d exp %0d", out_dest_index, e.dest));
        if ($unsigned(out_src_index) !== e.src)
          report($sformatf("src %h exp %h (dest %0d)", out_src_index, e.src, e.dest));
        if (out_pixel_color !== e.color)
          report($sformatf("color %h exp %h (dest %0d)", out_pixel_color, e.color, e.dest));
        if (out_run_last !== e.last)
          report($sformatf("run_last %b exp %b (dest %0d)", out_run_last, e.last, e.dest));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (out_done) begin
      out_done = 0;
      out_stall = fast ? 0 : $urandom_range(0, 11);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic put_word(input logic [15:0] w, input logic fs);
    word_t it;
    it.w = w;
    it.fs = fs;
    pend_words.push_back(it);
    gen_count++;
  endtask

  task automatic drain();
    while (pend_words.size() > 0 || in_valid || pix_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [5:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == dxtmv_pkg::CFG_WIDTH) m_width = val[4:0];
    else m_height = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one frame of well-formed content, cut short after max_words
  task automatic gen_frame(input int wb, input int hb, input int max_words);
    logic [15:0] fl;
    int units, start;
    start = gen_count;
    put_word({9'($urandom_range(0, 511)), 1'b0, 6'($urandom)}, 1'b1);
    put_word(16'($urandom), 1'b0);
    for (int r = 0; r < hb; r++) begin
      for (int c = 0; c < wb; c++) begin
        if (gen_count - start >= max_words) return;
        if (c % 16 == 0) begin
          fl = 16'($urandom);
          put_word(fl, 1'b0);
        end
        units = fl[0] ? 4 : 1;
        for (int u = 0; u < units; u++) begin
          if ($urandom_range(0, 2) == 0) begin
            put_word({1'b1, 15'($urandom)}, 1'b0);
          end else begin
            put_word({1'b0, 15'($urandom)}, 1'b0);
            put_word(16'($urandom), 1'b0);
            repeat (fl[0] ? 2 : 8) put_word(16'($urandom), 1'b0);
          end
        end
        fl = fl >> 1;
      end
    end
    if ($urandom_range(0, 1)) put_word(16'($urandom), 1'b0);
  endtask

  task automatic random_phase(input int wb, input int hb, input int budget);
    int stop;
    stop = gen_count + budget;
    while (gen_count < stop) begin
      case ($urandom_range(0, 9))
        0: begin
          put_word({9'($urandom_range(0, 511)), 1'b1, 6'($urandom)}, 1'b1);
          repeat ($urandom_range(1, 3)) put_word(16'($urandom), 1'b0);
        end
        1: repeat ($urandom_range(1, 3)) put_word(16'($urandom), 1'($urandom));
        default: gen_frame(wb, hb, $urandom_range(4, 60));
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = dxtmv_pkg::CFG_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_stream_word = '0;
    in_frame_start = 1'b0;
    out_ready = 1'b0;
    gen_count = 0;
    model_reset();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: stray words, kept header, then one frame with corner content
    put_word(16'hFFFF, 1'b0);
    put_word(16'h0040, 1'b1);
    put_word(16'h8000, 1'b0);
    put_word(16'hFFBF, 1'b1);
    put_word(16'h0000, 1'b0);
    put_word(16'h0002, 1'b0);
    put_word(16'h8000, 1'b0);
    put_word(16'hFFFF, 1'b0);
    put_word(16'hC3FF, 1'b0);
    put_word(16'h83E0, 1'b0);
    put_word(16'h801F, 1'b0);
    put_word(16'h7FFF, 1'b0);
    put_word(16'h0000, 1'b0);
    repeat (2) put_word(16'hE4E4, 1'b0);
    put_word(16'h0000, 1'b0);
    put_word(16'hFFFF, 1'b0);
    repeat (8) put_word(16'h1B1B, 1'b0);
    put_word(16'h1234, 1'b0);
    put_word(16'h0000, 1'b1);
    drain();

    write_reg(dxtmv_pkg::CFG_WIDTH, 6'd1);
    write_reg(dxtmv_pkg::CFG_HEIGHT, 6'd1);
    random_phase(1, 1, 40);
    drain();

    write_reg(dxtmv_pkg::CFG_WIDTH, 6'd17);
    write_reg(dxtmv_pkg::CFG_HEIGHT, 6'd2);
    hold_req = 1;
    random_phase(17, 2, 60);
    drain();

    fast = 1;
    write_reg(dxtmv_pkg::CFG_WIDTH, 6'd31);
    write_reg(dxtmv_pkg::CFG_HEIGHT, 6'd63);
    random_phase(31, 63, 40);
    drain();

    fast = 0;
    write_reg(dxtmv_pkg::CFG_WIDTH, 6'd0);
    write_reg(dxtmv_pkg::CFG_HEIGHT, 6'd3);
    random_phase(2, 3, 15);
    drain();

    write_reg(dxtmv_pkg::CFG_WIDTH, 6'd2);
    write_reg(dxtmv_pkg::CFG_HEIGHT, 6'd0);
    random_phase(2, 2, 15);
    drain();

    write_reg(dxtmv_pkg::CFG_WIDTH, 6'd3);
    write_reg(dxtmv_pkg::CFG_HEIGHT, 6'd2);
    random_phase(3, 2, 80);
    drain();

    write_reg(dxtmv_pkg::CFG_WIDTH, 6'd30);
    write_reg(dxtmv_pkg::CFG_HEIGHT, 6'd32);
    random_phase(30, 32, 70);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
